FILE: rtl/aarm_pkg.sv
// aarm_pkg: shared types and status codes for the adc average range monitor
// no dependencies; imported by adc_average_range_monitor
`default_nettype none

package aarm_pkg;

  localparam int CH_W   = 4;   // channel field width
  localparam int SMP_W  = 8;   // sample, limit and average width
  localparam int SUM_W  = 14;  // running sum width
  localparam int CNT_W  = 6;   // sample count width
  localparam int DEB_W  = 8;   // debounce counter and register width
  localparam int STAT_W = 2;   // status code width

  localparam logic [STAT_W-1:0] ST_NORMAL = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER   = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER  = 2'd2;

  localparam logic [DEB_W-1:0] DEB_RESET = 8'd3;

  // one input transaction as held in the input register
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
    logic [SMP_W-1:0] high_limit;
    logic [SMP_W-1:0] low_limit;
  } in_item_t;

  // one result transaction as held in the output register
  typedef struct packed {
    logic [CH_W-1:0]   channel_out;
    logic              done_res;
    logic [SMP_W-1:0]  average;
    logic [STAT_W-1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/adc_average_range_monitor.sv
// adc_average_range_monitor: per-channel block averaging with a debounced
// window comparator. Depends on aarm_pkg.
//
// Usage:
//  - input channel (in_valid / in_stall): one sample per transaction with its
//    channel number and that channel's upper and lower limits
//  - result channel (out_valid / out_stall): exactly one result per input
//    transaction, in order: channel echo, block-done flag, latest average and
//    status (normal / over / under)
//  - config channel (cfg_valid / cfg_ready / cfg_data): debounce count, always
//    ready; write only while no transaction is in flight
//  - the input is captured in the input register and the result in the result
//    register; one transaction per cycle is sustained while the receiver does
//    not stall, since the per-channel read-modify-write of the state registers
//    is combinational between the input register and the result register
//  - the average is formed by a reciprocal multiply of the block sum
//  - synchronous reset clears all per-channel state, sets the debounce count
//    to 3 and empties both registers
//  - when the receiver stalls, the result register holds; the input register
//    still takes one more transaction, after which in_stall is raised
`default_nettype none

module adc_average_range_monitor
  import aarm_pkg::*;
#(
  parameter int CHANNELS  = 16,
  parameter int AVG_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CH_W-1:0]   in_channel,
  input  wire logic [SMP_W-1:0]  in_sample,
  input  wire logic [SMP_W-1:0]  in_high_limit,
  input  wire logic [SMP_W-1:0]  in_low_limit,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CH_W-1:0]        out_channel_out,
  output logic                   out_done_res,
  output logic [SMP_W-1:0]       out_average,
  output logic [STAT_W-1:0]      out_status,

  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DEB_W-1:0]  cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W:0]    CH_LIM  = (CH_W + 1)'(CHANNELS);
  localparam logic [CNT_W:0]   AVG_LIM = (CNT_W + 1)'(AVG_COUNT);
  // reciprocal of the block length, exact for every 14-bit sum
  localparam int               RCP_SH  = 21;
  localparam int               RCP_W   = RCP_SH + 1;
  localparam logic [RCP_W-1:0] RECIP   =
    RCP_W'(((2 ** RCP_SH) + AVG_COUNT - 1) / AVG_COUNT);
  localparam int               PROD_W  = SUM_W + RCP_W;

  // pipeline registers
  logic      s1_vld_r, s1_vld_nxt;
  in_item_t  s1_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      s1_adv;
  logic      in_acc;

  logic [DEB_W-1:0] deb_times_r;

  // per-channel state
  logic [SUM_W-1:0]  sum_r   [CHANNELS];
  logic [CNT_W-1:0]  cnt_r   [CHANNELS];
  logic [SMP_W-1:0]  avg_r   [CHANNELS];
  logic [STAT_W-1:0] stat_r  [CHANNELS];
  logic [DEB_W-1:0]  deb_r   [CHANNELS];

  logic [IDX_W-1:0]  idx;
  logic              ch_ok;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W:0]    cnt_inc;
  logic              blk_done;
  logic [PROD_W-1:0] prod;
  logic [SMP_W-1:0]  avg_new;
  logic [STAT_W-1:0] st_cur;
  logic              qual;
  logic [STAT_W-1:0] tgt;
  logic [DEB_W-1:0]  deb_inc;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [SMP_W-1:0]  avg_nxt;
  logic [STAT_W-1:0] stat_nxt;
  logic [DEB_W-1:0]  deb_nxt;

  // handshake
  assign s1_adv      = s1_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall    = s1_vld_r & ~s1_adv;
  assign in_acc      = in_valid & ~in_stall;
  assign s1_vld_nxt  = in_acc | (s1_vld_r & ~s1_adv);
  assign out_vld_nxt = s1_adv | (out_vld_r & out_stall);
  assign cfg_ready   = 1'b1;

  // per-channel read-modify-write
  assign idx      = s1_item_r.channel[IDX_W-1:0];
  assign ch_ok    = {1'b0, s1_item_r.channel} < CH_LIM;
  assign sum_add  = sum_r[idx] + SUM_W'(s1_item_r.sample);
  assign cnt_inc  = {1'b0, cnt_r[idx]} + (CNT_W + 1)'(1);
  assign blk_done = cnt_inc >= AVG_LIM;
  assign prod     = PROD_W'(sum_add) * PROD_W'(RECIP);
  assign avg_new  = prod[RCP_SH +: SMP_W];
  assign st_cur   = stat_r[idx];
  assign deb_inc  = deb_r[idx] + DEB_W'(1);

  // window comparison, checks in priority order per current status
  always_comb begin
    qual = 1'b0;
    tgt  = st_cur;
    unique case (st_cur)
      ST_NORMAL: begin
        if (avg_new >= s1_item_r.high_limit) begin
          qual = 1'b1;
          tgt  = ST_OVER;
        end else if (avg_new <= s1_item_r.low_limit) begin
          qual = 1'b1;
          tgt  = ST_UNDER;
        end
      end
      ST_OVER: begin
        if (avg_new <= s1_item_r.low_limit) begin
          qual = 1'b1;
          tgt  = ST_UNDER;
        end else if (avg_new < s1_item_r.high_limit) begin
          qual = 1'b1;
          tgt  = ST_NORMAL;
        end
      end
      ST_UNDER: begin
        if (avg_new >= s1_item_r.high_limit) begin
          qual = 1'b1;
          tgt  = ST_OVER;
        end else if (avg_new > s1_item_r.low_limit) begin
          qual = 1'b1;
          tgt  = ST_NORMAL;
        end
      end
      default: begin
        qual = 1'b0;
        tgt  = st_cur;
      end
    endcase
  end

  always_comb begin
    sum_nxt  = sum_add;
    cnt_nxt  = cnt_inc[CNT_W-1:0];
    avg_nxt  = avg_r[idx];
    stat_nxt = st_cur;
    deb_nxt  = deb_r[idx];
    if (blk_done) begin
      sum_nxt = '0;
      cnt_nxt = '0;
      avg_nxt = avg_new;
      // unknown status code leaves counter and status alone
      if (st_cur == ST_NORMAL || st_cur == ST_OVER || st_cur == ST_UNDER) begin
        if (!qual) begin
          deb_nxt = '0;
        end else if (deb_inc >= deb_times_r) begin
          deb_nxt  = '0;
          stat_nxt = tgt;
        end else begin
          deb_nxt = deb_inc;
        end
      end
    end
  end

  always_comb begin
    out_item_nxt.channel_out = s1_item_r.channel;
    out_item_nxt.done_res    = ch_ok & blk_done;
    out_item_nxt.average     = ch_ok ? avg_nxt : '0;
    out_item_nxt.status      = ch_ok ? stat_nxt : ST_NORMAL;
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      deb_times_r <= DEB_RESET;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        deb_times_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.channel    <= in_channel;
      s1_item_r.sample     <= in_sample;
      s1_item_r.high_limit <= in_high_limit;
      s1_item_r.low_limit  <= in_low_limit;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  // channel state, written as a transaction for a valid channel moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        cnt_r[i]  <= '0;
        avg_r[i]  <= '0;
        stat_r[i] <= ST_NORMAL;
        deb_r[i]  <= '0;
      end
    end else if (s1_adv && ch_ok) begin
      sum_r[idx]  <= sum_nxt;
      cnt_r[idx]  <= cnt_nxt;
      avg_r[idx]  <= avg_nxt;
      stat_r[idx] <= stat_nxt;
      deb_r[idx]  <= deb_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_channel_out = out_item_r.channel_out;
  assign out_done_res    = out_item_r.done_res;
  assign out_average     = out_item_r.average;
  assign out_status      = out_item_r.status;

endmodule

`default_nettype wire
